// ===== sv/rsd_pkg.sv =====
// Shared types and constants for the RLE stream decoder and checker.
// No dependencies; imported by every module of the block.
package rsd_pkg;

    // Decoder phases.
    localparam logic [2:0] PH_HDR  = 3'd0;
    localparam logic [2:0] PH_CTRL = 3'd1;
    localparam logic [2:0] PH_RUNB = 3'd2;
    localparam logic [2:0] PH_LIT  = 3'd3;
    localparam logic [2:0] PH_PAD  = 3'd4;
    localparam logic [2:0] PH_ERR  = 3'd5;

    // Status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
    localparam logic [2:0] ST_OVERRUN   = 3'd2;
    localparam logic [2:0] ST_TRUNC     = 3'd3;
    localparam logic [2:0] ST_PADDING   = 3'd4;

    localparam logic [7:0] MAGIC_BYTE   = 8'h30;
    localparam logic [6:0] LEN_MASK     = 7'h7F;
    localparam logic [7:0] RUN_BIAS     = 8'd3;
    localparam logic [7:0] LIT_BIAS     = 8'd1;
    localparam logic [2:0] PAD_LIMIT    = 3'd3;
    localparam logic [2:0] PAD_SAT      = 3'd7;

    // Job queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // One decoded step: the byte to emit, how many copies, and the step's status.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic [7:0]  nbytes;
        logic [2:0]  status;
        logic        done;
        logic [23:0] total_size;
    } t_job;

endpackage

// ===== sv/rle_stream_decoder_checker_unit.sv =====
// Top level of the RLE stream decoder and checker (run-length type 0x30).
// Instantiates rsd_front, rsd_queue and rsd_back; depends on rsd_pkg.
//
// Channel   Dir  Signals                         Contents
// s_axis    in   tvalid tready tdata[7:0] tlast  compressed byte, tlast = final byte
// m_axis    out  tvalid tready tdata[63:0] tlast decoded word and status, tlast = last
//                                                word caused by one input byte
//
// One compressed byte is taken per cycle while the two-entry job queue has room.
// A byte that decodes to n bytes leaves as max(1, ceil(n / lanes)) words, 33 for a
// 130-byte run at four lanes, one per ready cycle from the back's output register.
// Synchronous active-low reset clears all control state; no clearing pass.
// A stalled m_axis fills the queue and then holds s_axis_tready low.
module rle_stream_decoder_checker_unit import rsd_pkg::*; #(
    parameter int SIZE_BITS = 24,
    parameter int OUT_LANES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] out_data, [34:32] out_count,
                                        // [37:35] status, [38] done_res,
                                        // [62:39] total_size, [63] zero
    output logic        m_axis_tlast
);

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_job job_in;
    t_job job_head;

    assign s_axis_tready = !full;

    rsd_front #(.SIZE_BITS(SIZE_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_full  (full),
        .o_push  (push),
        .o_job   (job_in)
    );

    rsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (job_head)
    );

    rsd_back #(.OUT_LANES(OUT_LANES)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_head        (job_head),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== sv/rsd_front.sv =====
// Front part: parses the header and control bytes, tracks sizes and errors.
// Emits one job per accepted byte into the job queue. Depends on rsd_pkg.
module rsd_front import rsd_pkg::*; #(
    parameter int SIZE_BITS = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_full,
    output logic       o_push,
    output t_job       o_job
);

    logic [2:0]           r_phase, n_phase;
    logic [1:0]           r_hidx, n_hidx;
    logic [SIZE_BITS-1:0] r_exp, n_exp;
    logic [SIZE_BITS-1:0] r_prod, n_prod;
    logic [7:0]           r_chunk, n_chunk;
    logic [2:0]           r_pad, n_pad;
    logic [2:0]           r_err, n_err;

    logic [23:0]          hdr_sh;
    logic [7:0]           len;
    logic [SIZE_BITS-1:0] room;
    logic [7:0]           nbytes;
    logic                 done;
    logic                 accept;

    assign accept = i_valid && !i_full;
    assign o_push = accept;

    always_comb begin
        case (r_hidx)
            2'd1:    hdr_sh = {16'b0, i_byte};
            2'd2:    hdr_sh = {8'b0, i_byte, 8'b0};
            default: hdr_sh = {i_byte, 16'b0};
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_hidx  = r_hidx;
        n_exp   = r_exp;
        n_prod  = r_prod;
        n_chunk = r_chunk;
        n_pad   = r_pad;
        n_err   = r_err;
        nbytes  = 8'd0;
        len     = 8'd0;
        room    = '0;
        case (r_phase)
            PH_HDR: begin
                if (r_hidx == 2'd0) begin
                    if (i_byte != MAGIC_BYTE) begin
                        if (n_err == ST_OK) n_err = ST_BAD_MAGIC;
                        n_phase = PH_ERR;
                    end else begin
                        n_hidx = 2'd1;
                    end
                end else begin
                    n_exp = r_exp | hdr_sh[SIZE_BITS-1:0];
                    if (r_hidx == 2'd3) begin
                        n_hidx  = 2'd0;
                        n_phase = (n_exp == '0) ? PH_PAD : PH_CTRL;
                    end else begin
                        n_hidx = r_hidx + 2'd1;
                    end
                end
            end
            PH_CTRL: begin
                if (i_byte[7]) begin
                    len     = {1'b0, i_byte[6:0] & LEN_MASK} + RUN_BIAS;
                    n_phase = PH_RUNB;
                end else begin
                    len     = {1'b0, i_byte[6:0] & LEN_MASK} + LIT_BIAS;
                    n_phase = PH_LIT;
                end
                if (({1'b0, r_prod} + (SIZE_BITS+1)'(len)) > {1'b0, r_exp}) begin
                    if (n_err == ST_OK) n_err = ST_OVERRUN;
                end
                n_chunk = len;
            end
            PH_RUNB: begin
                room    = (r_exp > r_prod) ? (r_exp - r_prod) : '0;
                nbytes  = (SIZE_BITS'(r_chunk) < room) ? r_chunk : room[7:0];
                n_prod  = r_prod + SIZE_BITS'(nbytes);
                n_chunk = 8'd0;
                n_phase = (n_prod >= r_exp) ? PH_PAD : PH_CTRL;
            end
            PH_LIT: begin
                if (r_prod < r_exp) begin
                    nbytes = 8'd1;
                    n_prod = r_prod + SIZE_BITS'(1);
                end
                if (r_chunk != 8'd0) n_chunk = r_chunk - 8'd1;
                if (n_chunk == 8'd0) n_phase = (n_prod >= r_exp) ? PH_PAD : PH_CTRL;
            end
            PH_PAD: begin
                if (r_pad < PAD_SAT) n_pad = r_pad + 3'd1;
                if (n_pad > PAD_LIMIT) begin
                    if (n_err == ST_OK) n_err = ST_PADDING;
                end
            end
            default: begin
            end
        endcase
        done = 1'b0;
        if (i_last) begin
            if (n_phase == PH_HDR || n_phase == PH_CTRL || n_phase == PH_RUNB ||
                n_phase == PH_LIT) begin
                if (n_err == ST_OK) n_err = ST_TRUNC;
            end
            done = (n_phase == PH_PAD);
        end
    end

    always_comb begin
        o_job.data_byte  = i_byte;
        o_job.nbytes     = nbytes;
        o_job.status     = n_err;
        o_job.done       = done;
        o_job.total_size = 24'(n_exp);
    end

    // The final byte of a stream returns everything to reset for the next stream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_last)) begin
            r_phase <= PH_HDR;
            r_hidx  <= 2'd0;
            r_exp   <= '0;
            r_prod  <= '0;
            r_chunk <= 8'd0;
            r_pad   <= 3'd0;
            r_err   <= ST_OK;
        end else if (accept) begin
            r_phase <= n_phase;
            r_hidx  <= n_hidx;
            r_exp   <= n_exp;
            r_prod  <= n_prod;
            r_chunk <= n_chunk;
            r_pad   <= n_pad;
            r_err   <= n_err;
        end
    end

endmodule

// ===== sv/rsd_queue.sv =====
// Short job queue that decouples the parsing front from the output back.
// Depends on rsd_pkg for the job type and depth.
module rsd_queue import rsd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

// ===== sv/rsd_back.sv =====
// Back part: expands each job into packed output words of up to LANES bytes.
// Holds the output register of the master stream. Depends on rsd_pkg.
module rsd_back import rsd_pkg::*; #(
    parameter int OUT_LANES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_job        i_head,
    output logic        o_pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    localparam int LANES = (OUT_LANES > 4) ? 4 : ((OUT_LANES < 1) ? 1 : OUT_LANES);

    t_job        r_job;
    logic [7:0]  r_left;
    logic        r_act;
    logic        r_ov;
    logic [31:0] r_odata;
    logic [2:0]  r_ocnt;
    logic        r_olast;
    logic [2:0]  r_ostat;
    logic        r_odone;
    logic [23:0] r_ototal;

    logic        load;
    logic        have;
    t_job        src;
    logic [7:0]  src_left;
    logic [7:0]  cnt;
    logic [7:0]  rem;
    logic [31:0] n_odata;

    assign load     = !r_ov || m_axis_tready;
    assign have     = r_act || !i_empty;
    assign src      = r_act ? r_job : i_head;
    assign src_left = r_act ? r_left : i_head.nbytes;
    assign o_pop    = load && !r_act && !i_empty;
    assign cnt      = (src_left > 8'(LANES)) ? 8'(LANES) : src_left;
    assign rem      = src_left - cnt;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_odata[8*i +: 8] = (8'(i) < cnt) ? src.data_byte : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_act <= 1'b0;
        end else if (load) begin
            r_ov  <= have;
            r_act <= have && (rem != 8'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && have) begin
            r_job    <= src;
            r_left   <= rem;
            r_odata  <= n_odata;
            r_ocnt   <= cnt[2:0];
            r_olast  <= (rem == 8'd0);
            r_ostat  <= src.status;
            r_odone  <= src.done;
            r_ototal <= src.total_size;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {1'b0, r_ototal, r_odone, r_ostat, r_ocnt, r_odata};

endmodule

// ===== sv/rsd_checker.sv =====
// Port-level assertions for the RLE stream decoder and checker.
// Attached to rle_stream_decoder_checker_unit by the bind statement below.
module rsd_checker import rsd_pkg::*; #(
    parameter int OUT_LANES = 4
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    localparam int LANES = (OUT_LANES > 4) ? 4 : ((OUT_LANES < 1) ? 1 : OUT_LANES);

    // A stalled output transfer keeps its word.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // Only the final word of an input byte may be partly filled.
    a_full_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[34:32] == 3'(LANES))
        else $error("non-final word not fully packed");

    // An empty word stands alone for its input byte.
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[34:32] == 3'd0 |-> m_axis_tlast)
        else $error("empty word not marked last");

    // A stream that ended properly cannot carry a magic or truncation error.
    a_done_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[38] |->
        m_axis_tdata[37:35] != ST_BAD_MAGIC && m_axis_tdata[37:35] != ST_TRUNC)
        else $error("done with inconsistent status");

endmodule

bind rle_stream_decoder_checker_unit rsd_checker #(.OUT_LANES(OUT_LANES)) u_rsd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
